// File: design/dpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg
// shared widths, register map, configuration and pipeline cell types
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int ERR_W   = 32;            // timing error and correction width
	localparam int DIV_W   = 16;            // divisor register width
	localparam int THR_W   = 31;            // deadband and threshold width
	localparam int ADDR_W  = 4;             // apb byte address width
	localparam int STEPS   = ERR_W;         // one quotient bit per cell
	localparam int LATENCY = STEPS + 4;     // front (2) + cells + back (2)

	typedef enum logic [1:0] {
		REG_DEADBAND  = 2'd0,
		REG_FAST_THR  = 2'd1,
		REG_SLOW_DIV  = 2'd2,
		REG_FAST_DIV  = 2'd3
	} reg_idx_t;

	// divisors are already forced nonzero
	typedef struct packed {
		logic [THR_W-1:0] deadband;
		logic [THR_W-1:0] fast_threshold;
		logic [DIV_W-1:0] slow_div;
		logic [DIV_W-1:0] fast_div;
	} cfg_t;

	// one restoring division lane: partial remainder and dividend/quotient word
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [ERR_W-1:0] dq;
	} lane_t;

	typedef struct packed {
		logic  valid;
		logic  active;
		logic  negative;
		lane_t slow;
		lane_t fast;
	} cell_t;

endpackage

// File: design/dpc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_regs
// apb configuration registers: deadband, fast threshold and the two divisors
// ----------------------------------------------------------------------------
module dpc_regs import dpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [THR_W-1:0] deadband_q;
	logic [THR_W-1:0] fast_thr_q;
	logic [DIV_W-1:0] slow_div_q;
	logic [DIV_W-1:0] fast_div_q;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= '0;
			fast_thr_q <= '0;
			slow_div_q <= DIV_W'(1);
			fast_div_q <= DIV_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_DEADBAND: deadband_q <= pwdata[THR_W-1:0];
				REG_FAST_THR: fast_thr_q <= pwdata[THR_W-1:0];
				REG_SLOW_DIV: slow_div_q <= pwdata[DIV_W-1:0];
				REG_FAST_DIV: fast_div_q <= pwdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEADBAND: prdata = 32'(deadband_q);
			REG_FAST_THR: prdata = 32'(fast_thr_q);
			REG_SLOW_DIV: prdata = 32'(slow_div_q);
			REG_FAST_DIV: prdata = 32'(fast_div_q);
			default:      prdata = '0;
		endcase
	end

	// a zero divisor acts as one
	assign cfg.deadband       = deadband_q;
	assign cfg.fast_threshold = fast_thr_q;
	assign cfg.slow_div       = (slow_div_q == '0) ? DIV_W'(1) : slow_div_q;
	assign cfg.fast_div       = (fast_div_q == '0) ? DIV_W'(1) : fast_div_q;

endmodule

// File: design/dpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_front
// magnitude and sign, then split into slow and fast dividends
// ----------------------------------------------------------------------------
module dpc_front import dpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [ERR_W-1:0] err,
	input  cfg_t             cfg,
	output cell_t            out
);

	logic             valid_s1;
	logic             neg_s1;
	logic [ERR_W-1:0] mag_s1;
	logic [ERR_W-1:0] db_ext;
	logic [ERR_W-1:0] thr_ext;
	logic [ERR_W-1:0] slow_top;
	logic [ERR_W-1:0] slow_num;
	logic [ERR_W-1:0] fast_num;
	cell_t            cell_s2;

	// stage 1: sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= err[ERR_W-1];
		mag_s1 <= err[ERR_W-1] ? ERR_W'(~err + 1'b1) : err;
	end

	// stage 2: piecewise split
	assign db_ext   = ERR_W'(cfg.deadband);
	assign thr_ext  = ERR_W'(cfg.fast_threshold);
	assign slow_top = (mag_s1 < thr_ext) ? mag_s1 : thr_ext;
	assign slow_num = (slow_top > db_ext) ? ERR_W'(slow_top - db_ext) : '0;
	assign fast_num = (mag_s1 > thr_ext) ? ERR_W'(mag_s1 - thr_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s2 <= '0;
		end else begin
			cell_s2.valid     <= valid_s1;
			cell_s2.active    <= mag_s1 > db_ext;
			cell_s2.negative  <= neg_s1;
			cell_s2.slow.rem  <= '0;
			cell_s2.slow.dq   <= slow_num;
			cell_s2.fast.rem  <= '0;
			cell_s2.fast.dq   <= fast_num;
		end
	end

	assign out = cell_s2;

endmodule

// File: design/dpc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_div_cell
// one restoring division step for the slow and fast lanes
// ----------------------------------------------------------------------------
module dpc_div_cell import dpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_t            in,
	input  logic [DIV_W-1:0] slow_div,
	input  logic [DIV_W-1:0] fast_div,
	output cell_t            out
);

	function automatic lane_t div_step(input lane_t ln, input logic [DIV_W-1:0] d);
		logic [DIV_W:0] r_ext;
		logic [DIV_W:0] diff;
		logic           ge;
		lane_t          res;
		r_ext   = {ln.rem, ln.dq[ERR_W-1]};
		diff    = r_ext - {1'b0, d};
		ge      = r_ext >= {1'b0, d};
		res.rem = ge ? diff[DIV_W-1:0] : r_ext[DIV_W-1:0];
		res.dq  = {ln.dq[ERR_W-2:0], ge};
		return res;
	endfunction

	cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q.valid    <= in.valid;
			cell_q.active   <= in.active;
			cell_q.negative <= in.negative;
			cell_q.slow     <= div_step(in.slow, slow_div);
			cell_q.fast     <= div_step(in.fast, fast_div);
		end
	end

	assign out = cell_q;

endmodule

// File: design/dpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_back
// sum of quotients, minimum of one outside the deadband, sign restore
// ----------------------------------------------------------------------------
module dpc_back import dpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_t            in,
	output logic             done,
	output logic [ERR_W-1:0] corr
);

	logic             valid_s1;
	logic             active_s1;
	logic             neg_s1;
	logic [ERR_W-1:0] sum_s1;
	logic [ERR_W-1:0] fix;
	logic             done_q;
	logic [ERR_W-1:0] corr_q;

	// both quotients together never exceed the magnitude, so no carry out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in.valid;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		active_s1 <= in.active;
		neg_s1    <= in.negative;
		sum_s1    <= ERR_W'(in.slow.dq + in.fast.dq);
	end

	assign fix = !active_s1 ? '0 : ((sum_s1 == '0) ? ERR_W'(1) : sum_s1);

	always_ff @(posedge clk) begin
		corr_q <= neg_s1 ? ERR_W'('0 - fix) : fix;
	end

	assign done = done_q;
	assign corr = corr_q;

endmodule

// File: design/deadband_phase_correction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_phase_correction_core
// signed timing error in, signed phase correction out, through a deadband
// and a two-slope divided gain
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  -------   -------------------------------------   -----------------------------
//  in        start, busy, timing_error[31:0]         taken when start & !busy
//  out       done, correction[31:0]                  one-cycle strobe, no stall
//  cfg       psel, penable, pwrite, paddr[3:0],      apb, write on access phase,
//            pwdata, prdata, pready                  regs at 0x0 0x4 0x8 0xc
//
//  one item per clock; busy stays low, the whole path is a pipeline
//  from the accepting edge to the done strobe an item goes through two front
//  stages, 32 division cells (one quotient bit each, both divisors in parallel)
//  and two back stages
//  reset clears every valid bit and restores the register defaults; no
//  clearing pass is needed
//  results cannot be held off, so nothing in the pipe ever stalls
// ----------------------------------------------------------------------------
module deadband_phase_correction_core import dpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// item in
	input  logic                    start,
	output logic                    busy,
	input  logic signed [ERR_W-1:0] timing_error,
	// item out
	output logic                    done,
	output logic signed [ERR_W-1:0] correction,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	cfg_t             cfg;
	cell_t            chain [STEPS+1];
	logic [ERR_W-1:0] corr;

	// the pipe never backs up
	assign busy = 1'b0;

	dpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// magnitude, sign and the split into slow and fast dividends
	dpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.err      (ERR_W'(timing_error)),
		.cfg      (cfg),
		.out      (chain[0])
	);

	// row of division cells; cell k produces quotient bit STEPS-1-k of each lane
	// divisors come straight from the registers; the user must change them only while idle (not enforced)
	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		dpc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in       (chain[k]),
			.slow_div (cfg.slow_div),
			.fast_div (cfg.fast_div),
			.out      (chain[k+1])
		);
	end

	// add the two quotients, apply the floor of one and put the sign back
	dpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (chain[STEPS]),
		.done   (done),
		.corr   (corr)
	);

	assign correction = corr;

endmodule

// File: design/dpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_checker
// port-level checks on latency, sign and zero handling
// ----------------------------------------------------------------------------
module dpc_checker import dpc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic signed [ERR_W-1:0] timing_error,
	input logic                    done,
	input logic signed [ERR_W-1:0] correction
);

	// every accepted item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item without result");

	// no result without an item accepted the fixed latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted item");

	// a nonzero correction carries the error's sign
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && correction != '0) |->
			(correction[ERR_W-1] == $past(timing_error[ERR_W-1], LATENCY)))
		else $error("correction sign differs from error sign");

	// a zero error always lies inside the deadband
	a_zero_in: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(timing_error, LATENCY) == '0) |-> (correction == '0))
		else $error("zero error gave nonzero correction");

endmodule

bind deadband_phase_correction_core dpc_checker u_dpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.timing_error (timing_error),
	.done         (done),
	.correction   (correction)
);

// File: verif/dpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_scoreboard
// watches the item, result and register ports of the deadband phase
// correction core, predicts each correction and compares it in order
// ----------------------------------------------------------------------------
module dpc_scoreboard import dpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic signed [ERR_W-1:0] timing_error,
	input  logic                    done,
	input  logic signed [ERR_W-1:0] correction,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output int                      failures,
	output int                      pending
);

	typedef struct packed {
		logic [ERR_W-1:0] err;
		logic [ERR_W-1:0] corr;
	} expected_corr_t;

	// shadow copy of the register file
	logic [THR_W-1:0] deadband_q;
	logic [THR_W-1:0] threshold_q;
	logic [DIV_W-1:0] slow_div_q;
	logic [DIV_W-1:0] fast_div_q;

	expected_corr_t expected_corrections[$];
	int             item_no;

	// two-slope gain with deadband, sign restored at the end
	function automatic logic [ERR_W-1:0] predict_correction(input logic [ERR_W-1:0] err);
		logic           neg;
		longint unsigned mag;
		longint unsigned slow_mag;
		longint unsigned db;
		longint unsigned thr;
		longint unsigned sdiv;
		longint unsigned fdiv;
		longint unsigned corr;
		neg  = err[ERR_W-1];
		mag  = neg ? ((64'd1 << ERR_W) - longint'(err)) : longint'(err);
		db   = deadband_q;
		thr  = threshold_q;
		sdiv = (slow_div_q == '0) ? 1 : slow_div_q;
		fdiv = (fast_div_q == '0) ? 1 : fast_div_q;
		corr = 0;
		if (mag > db) begin
			slow_mag = (mag < thr) ? mag : thr;
			if (slow_mag > db)
				corr = (slow_mag - db) / sdiv;
			if (mag > thr)
				corr += (mag - thr) / fdiv;
			if (corr == 0)
				corr = 1;
			if (neg)
				corr = 0 - corr;
		end
		return corr[ERR_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		failures++;
	endtask

	initial failures = 0;

	always @(posedge clk or negedge arst_n) begin
		expected_corr_t exp_c;
		int             push;
		int             pop;
		if (!arst_n) begin
			deadband_q  <= '0;
			threshold_q <= '0;
			slow_div_q  <= DIV_W'(1);
			fast_div_q  <= DIV_W'(1);
			pending     <= 0;
			item_no     <= 0;
			expected_corrections.delete();
		end else begin
			push = 0;
			pop  = 0;
			// results first: an item accepted now cannot finish in the same cycle
			if (done) begin
				if (expected_corrections.size() == 0) begin
					report_mismatch($sformatf("correction %0d with no item outstanding",
						correction));
				end else begin
					exp_c = expected_corrections.pop_front();
					pop   = 1;
					if (correction !== exp_c.corr)
						report_mismatch($sformatf("error %0d: correction %0d, expected %0d",
							$signed(exp_c.err), correction, $signed(exp_c.corr)));
				end
			end
			if (start && !busy) begin
				exp_c.err  = timing_error;
				exp_c.corr = predict_correction(timing_error);
				expected_corrections.push_back(exp_c);
				push    = 1;
				item_no <= item_no + 1;
			end
			pending <= pending + push - pop;
			// register writes land on the access cycle
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_DEADBAND: deadband_q  <= pwdata[THR_W-1:0];
					REG_FAST_THR: threshold_q <= pwdata[THR_W-1:0];
					REG_SLOW_DIV: slow_div_q  <= pwdata[DIV_W-1:0];
					REG_FAST_DIV: fast_div_q  <= pwdata[DIV_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives timing errors and register settings into the deadband phase
// correction core; the checker beside it predicts and compares each correction
// ----------------------------------------------------------------------------
module testbench;
	import dpc_pkg::*;

	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 315;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [ERR_W-1:0] timing_error;
	logic                    done;
	logic signed [ERR_W-1:0] correction;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	int failures;
	int pending;

	// current thresholds, kept only to aim errors at the knees of the curve
	longint unsigned cur_deadband;
	longint unsigned cur_threshold;

	deadband_phase_correction_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.timing_error (timing_error),
		.done         (done),
		.correction   (correction),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	dpc_scoreboard u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.timing_error (timing_error),
		.done         (done),
		.correction   (correction),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.failures     (failures),
		.pending      (pending)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hard stop in case results never arrive
	initial begin
		#3_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// one apb write: setup cycle, then access until pready
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// registers may only change with nothing in flight
	task automatic write_config(input logic [31:0] db, input logic [31:0] thr,
		input logic [31:0] sdiv, input logic [31:0] fdiv);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		write_reg(REG_DEADBAND, db);
		write_reg(REG_FAST_THR, thr);
		write_reg(REG_SLOW_DIV, sdiv);
		write_reg(REG_FAST_DIV, fdiv);
		cur_deadband  = db[THR_W-1:0];
		cur_threshold = thr[THR_W-1:0];
		@(posedge clk);
	endtask

	// hold start until the item is taken; start stays high for a following item
	task automatic send_item(input logic [ERR_W-1:0] err);
		start        <= 1'b1;
		timing_error <= err;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// a fully random word, or a magnitude near the deadband or threshold,
	// between the two, small or at the extremes, then given a random sign
	function automatic logic [ERR_W-1:0] pick_error();
		longint mag;
		longint lo;
		longint hi;
		longint top;
		top = 64'd1 << (ERR_W - 1);
		lo  = (cur_deadband < cur_threshold) ? cur_deadband : cur_threshold;
		hi  = (cur_deadband < cur_threshold) ? cur_threshold : cur_deadband;
		case ($urandom_range(0, 6))
			0, 1: return $urandom();
			2: mag = longint'(cur_deadband) + $signed($urandom_range(0, 8)) - 4;
			3: mag = longint'(cur_threshold) + $signed($urandom_range(0, 8)) - 4;
			4: mag = $urandom_range(0, 300);
			5: mag = lo + longint'($urandom()) % (hi - lo + 1);
			default: begin
				case ($urandom_range(0, 3))
					0: mag = 0;
					1: mag = 1;
					2: mag = top - 1;
					default: mag = top;
				endcase
			end
		endcase
		if (mag < 0)
			mag = 0;
		if (mag > top)
			mag = top;
		if ($urandom_range(0, 1))
			mag = -mag;
		return mag[ERR_W-1:0];
	endfunction

	// threshold-like register: small, wide, zero or full scale
	function automatic logic [31:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			3: return $urandom_range(0, 1 << 20);
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	// divisor register: zero acts as one, extremes and small gains
	function automatic logic [31:0] pick_divisor();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 16'hffff;
			3: return $urandom();
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	initial begin
		logic [ERR_W-1:0] err;
		int               left;
		int               burst;
		arst_n       = 1'b0;
		start        = 1'b0;
		timing_error = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		cur_deadband  = 0;
		cur_threshold = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no deadband, unity gain
		send_item(32'sd0);
		send_item(32'sd1);
		send_item(-32'sd1);
		send_item(32'h7fff_ffff);
		send_item(32'h8000_0000);

		// knees of the curve, truncation to one, both extremes
		write_config(100, 1000, 4, 3);
		send_item(32'sd100);
		send_item(-32'sd100);
		send_item(32'sd101);
		send_item(32'sd104);
		send_item(32'sd1000);
		send_item(32'sd1001);
		send_item(-32'sd1003);
		send_item(32'h7fff_ffff);
		send_item(32'h8000_0000);

		// deadband above threshold: only the fast part counts; top bit ignored
		write_config(32'h8000_1388, 1000, 7, 5);
		send_item(32'sd5000);
		send_item(32'sd5001);
		send_item(-32'sd1001);
		send_item(-32'sd6000);

		// zero divisors act as one
		write_config(10, 20, 32'hffff_0000, 0);
		send_item(32'sd15);
		send_item(-32'sd25);
		send_item(32'sd10);

		// random phases: bursts with gaps, some run back to back
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: write_config(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 16'hffff);
				1: write_config(0, 32'h7fff_ffff, pick_divisor(), pick_divisor());
				default: write_config(pick_level(), pick_level(), pick_divisor(),
					pick_divisor());
			endcase
			left = ITEMS_PER_PHASE;
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && left > 0; k++) begin
					err = pick_error();
					send_item(err);
					left--;
				end
				if ($urandom_range(0, 3) != 0)
					idle_cycles($urandom_range(1, 6));
			end
		end

		// drain, with a bound, then let any stray strobe show up
		start <= 1'b0;
		for (int w = 0; w < 4 * LATENCY && pending != 0; w++)
			@(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/dpc_pkg.sv
design/dpc_regs.sv
design/dpc_front.sv
design/dpc_div_cell.sv
design/dpc_back.sv
design/deadband_phase_correction_core.sv
design/dpc_checker.sv
verif/dpc_checker.sv
verif/testbench.sv
